// ===== hw/rtl/mdtp_pkg.sv =====
// ----------------------------------------------------------------------------
// mdtp_pkg: shared types and constants for the mail date token parser
// Character codes, token phase encoding, month-name keys and the structs
// that pass token summaries and date fields between the modules.
// ----------------------------------------------------------------------------
package mdtp_pkg;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;

    localparam logic [15:0] YEAR_PIVOT = 16'd1900;
    localparam int          NUM_MONTHS = 12;

    // Letter codes are 1 for 'a' up to 26 for 'z'; a zero third key is a wildcard.
    localparam logic [4:0] MONTH_KEY0 [NUM_MONTHS] = '{
        5'd10, 5'd6, 5'd13, 5'd1, 5'd13, 5'd10, 5'd10, 5'd1, 5'd19, 5'd15, 5'd14, 5'd4};
    localparam logic [4:0] MONTH_KEY1 [NUM_MONTHS] = '{
        5'd1, 5'd5, 5'd1, 5'd16, 5'd1, 5'd21, 5'd21, 5'd21, 5'd5, 5'd3, 5'd15, 5'd5};
    localparam logic [4:0] MONTH_KEY2 [NUM_MONTHS] = '{
        5'd0, 5'd0, 5'd18, 5'd0, 5'd25, 5'd14, 5'd12, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0};

    typedef enum logic [3:0] {
        PH_START,
        PH_HSIGN,
        PH_HDIG,
        PH_COLON,
        PH_MSIGN,
        PH_MDIG,
        PH_STOP0,
        PH_STOPH,
        PH_STOPHM
    } t_phase;

    typedef enum logic [1:0] {
        FIRST_OTHER,
        FIRST_DIGIT,
        FIRST_SIGN
    } t_first;

    // What a finished token tells the date field logic.
    typedef struct packed {
        logic               nonempty;
        logic               colon;
        t_first             first;
        logic               hour_set;
        logic               minute_set;
        logic signed [15:0] hour;
        logic signed [15:0] minute;
        logic [15:0]        number;
        logic [6:0]         last_two;
        logic [3:0]         month;
    } t_tok_sum;

    typedef struct packed {
        logic [15:0]        day;
        logic [15:0]        month;
        logic [6:0]         year;
        logic signed [15:0] hour;
        logic signed [15:0] minute;
    } t_date;

    // Month number for a three-letter prefix, 0 when no name matches.
    // The scan runs from the last key down so that the first listed match wins.
    function automatic logic [3:0] month_lookup(input logic [14:0] prefix);
        logic [3:0] m;
        m = 4'd0;
        for (int i = NUM_MONTHS - 1; i >= 0; i--) begin
            if (prefix[14:10] == MONTH_KEY0[i] && prefix[9:5] == MONTH_KEY1[i] &&
                (MONTH_KEY2[i] == 5'd0 || prefix[4:0] == MONTH_KEY2[i])) begin
                m = 4'(i + 1);
            end
        end
        return m;
    endfunction

endpackage

// ===== hw/rtl/mdtp_token.sv =====
// ----------------------------------------------------------------------------
// mdtp_token: per-token character state
// Tracks the colon-form phase, the leading number, the minute number and the
// letter prefix of the current token, and presents a summary when it ends.
// ----------------------------------------------------------------------------
module mdtp_token (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  logic                i_finish,
    input  logic [7:0]          i_ch,
    output mdtp_pkg::t_tok_sum  o_sum
);

    mdtp_pkg::t_phase r_phase, n_phase;
    mdtp_pkg::t_first r_first, n_first;
    logic [15:0]      r_num, n_num;
    logic [6:0]       r_last, n_last;
    logic [15:0]      r_sec, n_sec;
    logic [14:0]      r_prefix, n_prefix;
    logic [1:0]       r_len, n_len;
    logic             r_colon, n_colon;
    logic             r_hneg, n_hneg;
    logic             r_mneg, n_mneg;

    logic       is_dig;
    logic       is_sgn;
    logic [3:0] dig_val;
    logic [4:0] letter;

    function automatic logic [15:0] sat_digit(input logic [15:0] acc, input logic [3:0] d);
        logic [19:0] v;
        v = 20'(acc) * 20'd10 + 20'(d);
        return (v > 20'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    // (last * 10 + d) mod 100; the quotient is below ten, so four conditional
    // subtractions of 800, 400, 200 and 100 leave the remainder.
    function automatic logic [6:0] mod_digit(input logic [6:0] last, input logic [3:0] d);
        logic [9:0] t;
        t = 10'(last) * 10'd10 + 10'(d);
        if (t >= 10'd800) t = t - 10'd800;
        if (t >= 10'd400) t = t - 10'd400;
        if (t >= 10'd200) t = t - 10'd200;
        if (t >= 10'd100) t = t - 10'd100;
        return t[6:0];
    endfunction

    function automatic logic [15:0] sat_signed(input logic [15:0] mag, input logic neg);
        logic [15:0] r;
        if (neg) begin
            r = mag[15] ? 16'h8000 : 16'(~mag + 16'd1);
        end else begin
            r = mag[15] ? 16'h7FFF : mag;
        end
        return r;
    endfunction

    always_comb begin
        is_dig  = (i_ch >= mdtp_pkg::CH_ZERO) && (i_ch <= mdtp_pkg::CH_NINE);
        is_sgn  = (i_ch == mdtp_pkg::CH_PLUS) || (i_ch == mdtp_pkg::CH_MINUS);
        dig_val = is_dig ? 4'(i_ch - mdtp_pkg::CH_ZERO) : 4'd0;
        if (i_ch >= mdtp_pkg::CH_UP_A && i_ch <= mdtp_pkg::CH_UP_Z) begin
            letter = 5'(i_ch - mdtp_pkg::CH_UP_A + 8'd1);
        end else if (i_ch >= mdtp_pkg::CH_LO_A && i_ch <= mdtp_pkg::CH_LO_Z) begin
            letter = 5'(i_ch - mdtp_pkg::CH_LO_A + 8'd1);
        end else begin
            letter = 5'd0;
        end
    end

    // Phase: next state.
    always_comb begin
        n_phase = r_phase;
        if (i_take) begin
            unique case (r_phase)
                mdtp_pkg::PH_START: begin
                    if (is_sgn)      n_phase = mdtp_pkg::PH_HSIGN;
                    else if (is_dig) n_phase = mdtp_pkg::PH_HDIG;
                    else             n_phase = mdtp_pkg::PH_STOP0;
                end
                mdtp_pkg::PH_HSIGN: begin
                    n_phase = is_dig ? mdtp_pkg::PH_HDIG : mdtp_pkg::PH_STOP0;
                end
                mdtp_pkg::PH_HDIG: begin
                    if (!is_dig) begin
                        n_phase = (i_ch == mdtp_pkg::CH_COLON) ? mdtp_pkg::PH_COLON
                                                              : mdtp_pkg::PH_STOPH;
                    end
                end
                mdtp_pkg::PH_COLON: begin
                    if (is_sgn)      n_phase = mdtp_pkg::PH_MSIGN;
                    else if (is_dig) n_phase = mdtp_pkg::PH_MDIG;
                    else             n_phase = mdtp_pkg::PH_STOPH;
                end
                mdtp_pkg::PH_MSIGN: begin
                    n_phase = is_dig ? mdtp_pkg::PH_MDIG : mdtp_pkg::PH_STOPH;
                end
                mdtp_pkg::PH_MDIG: begin
                    if (!is_dig) n_phase = mdtp_pkg::PH_STOPHM;
                end
                default: n_phase = r_phase;
            endcase
        end
    end

    // Phase: datapath updates.
    always_comb begin
        n_num    = r_num;
        n_last   = r_last;
        n_sec    = r_sec;
        n_hneg   = r_hneg;
        n_mneg   = r_mneg;
        n_prefix = r_prefix;
        n_len    = r_len;
        n_first  = r_first;
        n_colon  = r_colon;
        if (i_take) begin
            if (r_len == 2'd0) begin
                if (is_dig)      n_first = mdtp_pkg::FIRST_DIGIT;
                else if (is_sgn) n_first = mdtp_pkg::FIRST_SIGN;
                else             n_first = mdtp_pkg::FIRST_OTHER;
            end
            case (r_len)
                2'd0:    n_prefix[14:10] = letter;
                2'd1:    n_prefix[9:5]   = letter;
                2'd2:    n_prefix[4:0]   = letter;
                default: n_prefix        = r_prefix;
            endcase
            if (r_len != 2'd3) n_len = r_len + 2'd1;
            if (i_ch == mdtp_pkg::CH_COLON) n_colon = 1'b1;

            unique case (r_phase)
                mdtp_pkg::PH_START: begin
                    if (is_sgn) begin
                        n_hneg = (i_ch == mdtp_pkg::CH_MINUS);
                    end else if (is_dig) begin
                        n_num  = 16'(dig_val);
                        n_last = 7'(dig_val);
                    end
                end
                mdtp_pkg::PH_HSIGN: begin
                    if (is_dig) begin
                        n_num  = 16'(dig_val);
                        n_last = 7'(dig_val);
                    end
                end
                mdtp_pkg::PH_HDIG: begin
                    if (is_dig) begin
                        n_num  = sat_digit(r_num, dig_val);
                        n_last = mod_digit(r_last, dig_val);
                    end
                end
                mdtp_pkg::PH_COLON: begin
                    if (is_sgn)      n_mneg = (i_ch == mdtp_pkg::CH_MINUS);
                    else if (is_dig) n_sec  = 16'(dig_val);
                end
                mdtp_pkg::PH_MSIGN: begin
                    if (is_dig) n_sec = 16'(dig_val);
                end
                mdtp_pkg::PH_MDIG: begin
                    if (is_dig) n_sec = sat_digit(r_sec, dig_val);
                end
                default: n_num = r_num;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_finish) begin
            r_phase  <= mdtp_pkg::PH_START;
            r_first  <= mdtp_pkg::FIRST_OTHER;
            r_num    <= '0;
            r_last   <= '0;
            r_sec    <= '0;
            r_prefix <= '0;
            r_len    <= '0;
            r_colon  <= 1'b0;
            r_hneg   <= 1'b0;
            r_mneg   <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_first  <= n_first;
            r_num    <= n_num;
            r_last   <= n_last;
            r_sec    <= n_sec;
            r_prefix <= n_prefix;
            r_len    <= n_len;
            r_colon  <= n_colon;
            r_hneg   <= n_hneg;
            r_mneg   <= n_mneg;
        end
    end

    always_comb begin
        o_sum.nonempty   = (r_len != 2'd0);
        o_sum.colon      = r_colon;
        o_sum.first      = r_first;
        o_sum.hour_set   = (r_phase == mdtp_pkg::PH_HDIG)  || (r_phase == mdtp_pkg::PH_COLON) ||
                           (r_phase == mdtp_pkg::PH_MSIGN) || (r_phase == mdtp_pkg::PH_MDIG)  ||
                           (r_phase == mdtp_pkg::PH_STOPH) || (r_phase == mdtp_pkg::PH_STOPHM);
        o_sum.minute_set = (r_phase == mdtp_pkg::PH_MDIG) || (r_phase == mdtp_pkg::PH_STOPHM);
        o_sum.hour       = $signed(sat_signed(r_num, r_hneg));
        o_sum.minute     = $signed(sat_signed(r_sec, r_mneg));
        o_sum.number     = r_num;
        o_sum.last_two   = r_last;
        o_sum.month      = mdtp_pkg::month_lookup(r_prefix);
    end

`ifndef ASSERT_OFF
    a_empty_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len == 2'd0) |-> (r_phase == mdtp_pkg::PH_START))
        else $error("token phase moved without any character");
    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_finish |=> (r_len == 2'd0 && r_phase == mdtp_pkg::PH_START && !r_colon))
        else $error("token state not cleared after token end");
    a_last_two_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_last < 7'd100)
        else $error("last two digits out of range");
`endif

endmodule

// ===== hw/rtl/mdtp_fields.sv =====
// ----------------------------------------------------------------------------
// mdtp_fields: date field registers
// Applies the day, month, year, hour and minute rules to each finished token
// and clears the fields once the end of the text has been handled.
// ----------------------------------------------------------------------------
module mdtp_fields (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_finish,
    input  logic               i_end,
    input  mdtp_pkg::t_tok_sum i_sum,
    output mdtp_pkg::t_date    o_date
);

    mdtp_pkg::t_date r_date, n_date;

    always_comb begin
        n_date = r_date;
        if (i_finish && i_sum.nonempty) begin
            if (i_sum.colon) begin
                if (i_sum.hour_set)   n_date.hour   = i_sum.hour;
                if (i_sum.minute_set) n_date.minute = i_sum.minute;
            end else if (i_sum.first == mdtp_pkg::FIRST_SIGN) begin
                n_date = r_date;
            end else if (i_sum.first == mdtp_pkg::FIRST_DIGIT) begin
                if (r_date.month != 16'd0) begin
                    if (r_date.day == 16'd0)      n_date.day  = i_sum.number;
                    else if (r_date.year == 7'd0) n_date.year = i_sum.last_two;
                end else if (i_sum.number > mdtp_pkg::YEAR_PIVOT) begin
                    n_date.year = i_sum.last_two;
                end else if (r_date.day != 16'd0) begin
                    // A second small number means the first one was the month.
                    n_date.month = r_date.day;
                    n_date.day   = i_sum.number;
                end else begin
                    n_date.day = i_sum.number;
                end
            end else if (i_sum.month != 4'd0) begin
                n_date.month = 16'(i_sum.month);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_end) begin
            r_date <= '0;
        end else begin
            r_date <= n_date;
        end
    end

    assign o_date = n_date;

`ifndef ASSERT_OFF
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_end |=> (r_date == '0))
        else $error("date fields not cleared after end of text");
`endif

endmodule

// ===== hw/rtl/mail_date_token_parser.sv =====
// ----------------------------------------------------------------------------
// mail_date_token_parser: date text tokenizer and field extractor
// Input register, per-token state, date field rules and a result register.
// ----------------------------------------------------------------------------
// Each character transfer passes through the input register into the token
// logic, and a new character can be taken every cycle unless an end transfer
// is stalled. Characters split into tokens at spaces; a transfer with
// end_of_text set closes the last token and produces one result (day, month,
// year modulo 100, signed hour and minute), which the result register offers
// once the end transfer has left the input register, after which all state is
// clear for the next text. Only an end transfer waits on the output side:
// while a result is held and not yet taken, further characters keep flowing
// and the next end transfer stalls in the input register.
module mail_date_token_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_ch,
    input  logic               i_end_of_text,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [15:0]        o_day_value,
    output logic [15:0]        o_month_value,
    output logic [6:0]         o_year_value,
    output logic signed [15:0] o_hour_value,
    output logic signed [15:0] o_minute_value
);

    logic            r_in_valid;
    logic [7:0]      r_ch;
    logic            r_eot;
    logic            r_out_valid;
    mdtp_pkg::t_date r_out;

    logic               out_free;
    logic               proc_go;
    logic               tok_take;
    logic               tok_finish;
    logic               text_end;
    mdtp_pkg::t_tok_sum tok_sum;
    mdtp_pkg::t_date    next_date;

    always_comb begin
        out_free   = !r_out_valid || i_out_ready;
        proc_go    = r_in_valid && (!r_eot || out_free);
        text_end   = proc_go && r_eot;
        tok_take   = proc_go && !r_eot && (r_ch != mdtp_pkg::CH_SPACE);
        tok_finish = proc_go && (r_eot || r_ch == mdtp_pkg::CH_SPACE);
        o_in_ready = !r_in_valid || proc_go;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_ch  <= i_ch;
            r_eot <= i_end_of_text;
        end
    end

    mdtp_token u_token (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (tok_take),
        .i_finish (tok_finish),
        .i_ch     (r_ch),
        .o_sum    (tok_sum)
    );

    mdtp_fields u_fields (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_finish (tok_finish),
        .i_end    (text_end),
        .i_sum    (tok_sum),
        .o_date   (next_date)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (text_end) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (text_end) begin
            r_out <= next_date;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_day_value    = r_out.day;
    assign o_month_value  = r_out.month;
    assign o_year_value   = r_out.year;
    assign o_hour_value   = r_out.hour;
    assign o_minute_value = r_out.minute;

`ifndef ASSERT_OFF
    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        text_end |=> r_out_valid)
        else $error("end of text did not load a result");
    a_end_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_eot && r_out_valid && !i_out_ready) |-> !proc_go)
        else $error("end of text taken while a result was still held");
`endif

endmodule
